/* hw/rtl/otp_tag_record_scanner_macros.svh */
// Assertion macros shared by the tag record scanner.
`ifndef OTP_TAG_RECORD_SCANNER_MACROS_SVH
`define OTP_TAG_RECORD_SCANNER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define OTP_ASSERT_IMPL(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("otp_tag_record_scanner: assertion failed");

// Next-cycle implication, checked outside reset.
`define OTP_ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("otp_tag_record_scanner: assertion failed");

`endif

/* hw/rtl/otptag_pkg.sv */
// Types, constants and helpers for the OTP tag record scanner.
package otptag_pkg;

    localparam logic [15:0] AREA_START = 16'd4096;
    localparam logic [16:0] AREA_END   = 17'd8192;
    localparam logic [16:0] REC_BYTES  = 17'd8;

    localparam logic CMD_START  = 1'b0;
    localparam logic CMD_RECORD = 1'b1;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_NOT_FOUND  = 3'd1;
    localparam logic [2:0] ST_CHAIN      = 3'd2;
    localparam logic [2:0] ST_INCOMPLETE = 3'd3;
    localparam logic [2:0] ST_INVALID    = 3'd4;

    typedef struct packed {
        logic        command;
        logic [7:0]  wanted_tag;
        logic [15:0] capacity;
        logic [63:0] record_word;
        logic        read_error;
    } in_item_t;

    typedef struct packed {
        logic [47:0] chunk_data;
        logic [2:0]  chunk_bytes;
        logic [15:0] total_bytes;
        logic [2:0]  status;
        logic        last;
    } out_item_t;

    // Keeps the lowest n bytes of a six-byte data field.
    function automatic logic [47:0] byte_mask(input logic [2:0] n);
        logic [47:0] m;
        case (n)
            3'd0: m = 48'h0000_0000_0000;
            3'd1: m = 48'h0000_0000_00FF;
            3'd2: m = 48'h0000_0000_FFFF;
            3'd3: m = 48'h0000_00FF_FFFF;
            3'd4: m = 48'h0000_FFFF_FFFF;
            3'd5: m = 48'h00FF_FFFF_FFFF;
            default: m = 48'hFFFF_FFFF_FFFF;
        endcase
        return m;
    endfunction

endpackage

/* hw/rtl/otp_tag_record_scanner.sv */
// Top level of the OTP tag record scanner: input register, decision logic, result register.

`include "otp_tag_record_scanner_macros.svh"

// A start transfer arms a search for one tag id with a byte capacity; record transfers
// then stream the tag area in address order. Every transfer is registered, decided and,
// when it causes a result, placed in the result register, so the block takes one transfer
// per cycle while no result waits on m_ready. Both stages advance together and stall only
// while a result waits on m_ready. The user must write reserved_tag through cfg_we and
// cfg_wdata only while no search is running; the block itself does not enforce this.
module otp_tag_record_scanner (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [7:0]            cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  otptag_pkg::in_item_t  s_item,
    output logic                  m_valid,
    input  logic                  m_ready,
    output otptag_pkg::out_item_t m_item
);
    import otptag_pkg::*;

    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_SCAN   = 2'd1;
    localparam logic [1:0] PH_SKIP   = 2'd2;
    localparam logic [1:0] PH_GATHER = 2'd3;

    logic [7:0]  reserved_tag_reg;
    in_item_t    in_reg;
    logic        in_valid_reg;
    out_item_t   out_reg;
    logic        out_valid_reg;

    logic [1:0]  phase_reg,     phase_next;
    logic [15:0] offset_reg,    offset_next;
    logic [7:0]  target_reg,    target_next;
    logic [15:0] remaining_reg, remaining_next;
    logic [15:0] delivered_reg, delivered_next;

    logic        proceed;
    logic        res_fire;
    out_item_t   res_item;

    logic [7:0]  b7;
    logic [2:0]  size;
    logic        rec_valid;
    logic        cont;
    logic [7:0]  tag;
    logic [16:0] next_off;
    logic        at_end;
    logic [2:0]  take_n;
    logic [15:0] rem_after;
    logic [15:0] dlv_after;
    logic [47:0] take_data;

    assign proceed = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || proceed;
    assign m_valid = out_valid_reg;
    assign m_item  = out_reg;

    assign b7        = in_reg.record_word[63:56];
    assign size      = b7[7:5];
    assign rec_valid = (size != 3'd0) && (size != 3'd7);
    assign cont      = b7[4];
    assign tag       = in_reg.record_word[55:48] | {5'b0, b7[2], 2'b0};
    assign next_off  = {1'b0, offset_reg} + REC_BYTES;
    assign at_end    = next_off >= AREA_END;
    assign take_n    = ({13'b0, size} > remaining_reg) ? remaining_reg[2:0] : size;
    assign rem_after = remaining_reg - {13'b0, take_n};
    assign dlv_after = delivered_reg + {13'b0, take_n};
    assign take_data = in_reg.record_word[47:0] & byte_mask(take_n);

    always_comb begin
        phase_next     = phase_reg;
        offset_next    = offset_reg;
        target_next    = target_reg;
        remaining_next = remaining_reg;
        delivered_next = delivered_reg;
        res_fire       = 1'b0;
        res_item       = '{chunk_data: 48'b0, chunk_bytes: 3'b0, total_bytes: delivered_reg,
                           status: ST_NOT_FOUND, last: 1'b1};

        if (in_reg.command == CMD_START) begin
            target_next    = in_reg.wanted_tag;
            remaining_next = in_reg.capacity;
            delivered_next = 16'd0;
            res_item.total_bytes = 16'd0;
            if (in_reg.wanted_tag == reserved_tag_reg) begin
                res_fire        = 1'b1;
                res_item.status = ST_INVALID;
                phase_next      = PH_IDLE;
            end else if ({1'b0, AREA_START} >= AREA_END) begin
                res_fire   = 1'b1;
                phase_next = PH_IDLE;
            end else begin
                offset_next = AREA_START;
                phase_next  = PH_SCAN;
            end
        end else begin
            case (phase_reg)
                PH_SCAN, PH_GATHER: begin
                    if (in_reg.read_error || !rec_valid) begin
                        if (phase_reg == PH_GATHER) begin
                            res_fire        = 1'b1;
                            res_item.status = ST_CHAIN;
                            phase_next      = PH_IDLE;
                        end else if (at_end) begin
                            res_fire   = 1'b1;
                            phase_next = PH_IDLE;
                        end else begin
                            offset_next = next_off[15:0];
                        end
                    end else if (phase_reg == PH_GATHER || tag == target_reg) begin
                        res_fire             = 1'b1;
                        remaining_next       = rem_after;
                        delivered_next       = dlv_after;
                        res_item.chunk_data  = take_data;
                        res_item.chunk_bytes = take_n;
                        res_item.total_bytes = dlv_after;
                        res_item.status      = ST_OK;
                        if ((rem_after != 16'd0) && cont) begin
                            if (at_end) begin
                                res_item.status = ST_INCOMPLETE;
                                phase_next      = PH_IDLE;
                            end else begin
                                res_item.last = 1'b0;
                                offset_next   = next_off[15:0];
                                phase_next    = PH_GATHER;
                            end
                        end else begin
                            phase_next = PH_IDLE;
                        end
                    end else if (at_end) begin
                        res_fire   = 1'b1;
                        phase_next = PH_IDLE;
                    end else begin
                        offset_next = next_off[15:0];
                        phase_next  = cont ? PH_SKIP : PH_SCAN;
                    end
                end
                PH_SKIP: begin
                    if (at_end) begin
                        res_fire   = 1'b1;
                        phase_next = PH_IDLE;
                    end else begin
                        offset_next = next_off[15:0];
                        phase_next  = (!in_reg.read_error && cont) ? PH_SKIP : PH_SCAN;
                    end
                end
                default: begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reserved_tag_reg <= 8'd0;
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            phase_reg        <= PH_IDLE;
            offset_reg       <= 16'd0;
            target_reg       <= 8'd0;
            remaining_reg    <= 16'd0;
            delivered_reg    <= 16'd0;
        end else begin
            if (cfg_we) begin
                reserved_tag_reg <= cfg_wdata;
            end
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (proceed) begin
                phase_reg     <= phase_next;
                offset_reg    <= offset_next;
                target_reg    <= target_next;
                remaining_reg <= remaining_next;
                delivered_reg <= delivered_next;
                out_valid_reg <= res_fire;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_item;
        end
        if (proceed && res_fire) begin
            out_reg <= res_item;
        end
    end

    `OTP_ASSERT_IMPL(a_more_only_ok, aclk, aresetn, m_valid && !m_item.last, m_item.status == ST_OK)
    `OTP_ASSERT_IMPL(a_empty_chunk_zero, aclk, aresetn, m_valid && m_item.chunk_bytes == 3'd0, m_item.chunk_data == 48'd0)
    `OTP_ASSERT_IMPL(a_invalid_no_total, aclk, aresetn, m_valid && m_item.status == ST_INVALID, m_item.total_bytes == 16'd0 && m_item.last)
    `OTP_ASSERT_NEXT(a_last_goes_idle, aclk, aresetn, proceed && res_fire && res_item.last, phase_reg == PH_IDLE)

endmodule

/* sim/testbench.sv */
// Self-checking testbench for the OTP tag record scanner, with its own result predictor.
module testbench;
    import otptag_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    typedef enum logic [1:0] {SCAN_IDLE, SCAN_LOOK, SCAN_SKIP, SCAN_GATHER} scan_state_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       cfg_we = 1'b0;
    logic [7:0] cfg_wdata = 8'h00;
    logic       s_valid = 1'b0;
    logic       s_ready;
    in_item_t   s_item = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    out_item_t  m_item;

    in_item_t    pending_transfers[$];
    out_item_t   expected_chunks[$];
    int          items_queued = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    logic        in_taken = 1'b0;
    int          mismatches = 0;
    int          cycle_count = 0;

    scan_state_t scan_state = SCAN_IDLE;
    logic [16:0] rec_offset = '0;
    logic [7:0]  target_tag_q = '0;
    logic [15:0] remaining_q = '0;
    logic [15:0] delivered_q = '0;
    logic [7:0]  reserved_copy = '0;

    otp_tag_record_scanner u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic void expect_chunk(logic [47:0] data, logic [2:0] n, logic [2:0] st,
                                         logic fin);
        out_item_t r;
        r.chunk_data  = data;
        r.chunk_bytes = n;
        r.total_bytes = delivered_q;
        r.status      = st;
        r.last        = fin;
        expected_chunks.push_back(r);
        if (fin) begin
            scan_state = SCAN_IDLE;
        end
    endfunction

    function automatic void step_record(scan_state_t next_state);
        if (rec_offset + REC_BYTES >= AREA_END) begin
            expect_chunk('0, 3'd0, ST_NOT_FOUND, 1'b1);
        end else begin
            rec_offset = rec_offset + REC_BYTES;
            scan_state = next_state;
        end
    endfunction

    function automatic void take_chunk(logic [63:0] word, logic [2:0] size);
        logic [2:0]  n;
        logic [47:0] data;
        n = size;
        if ({13'd0, size} > remaining_q) begin
            n = remaining_q[2:0];
        end
        data = '0;
        for (int i = 0; i < 6; i++) begin
            if (i < n) begin
                data[8*i +: 8] = word[8*i +: 8];
            end
        end
        remaining_q = remaining_q - {13'd0, n};
        delivered_q = delivered_q + {13'd0, n};
        if (remaining_q != 0 && word[60]) begin
            if (rec_offset + REC_BYTES >= AREA_END) begin
                expect_chunk(data, n, ST_INCOMPLETE, 1'b1);
            end else begin
                rec_offset = rec_offset + REC_BYTES;
                scan_state = SCAN_GATHER;
                expect_chunk(data, n, ST_OK, 1'b0);
            end
        end else begin
            expect_chunk(data, n, ST_OK, 1'b1);
        end
    endfunction

    function automatic void track_transfer(in_item_t it);
        logic [7:0] b7;
        logic [2:0] size;
        logic       valid_rec;
        logic       cont;
        logic [7:0] tag;
        b7        = it.record_word[63:56];
        size      = b7[7:5];
        valid_rec = size != 3'd0 && size != 3'd7;
        cont      = b7[4];
        tag       = it.record_word[55:48] | (b7 & 8'h04);
        if (it.command == CMD_START) begin
            target_tag_q = it.wanted_tag;
            remaining_q  = it.capacity;
            delivered_q  = '0;
            if (target_tag_q == reserved_copy) begin
                expect_chunk('0, 3'd0, ST_INVALID, 1'b1);
            end else if ({1'b0, AREA_START} >= AREA_END) begin
                expect_chunk('0, 3'd0, ST_NOT_FOUND, 1'b1);
            end else begin
                rec_offset = {1'b0, AREA_START};
                scan_state = SCAN_LOOK;
            end
        end else begin
            case (scan_state)
                SCAN_LOOK: begin
                    if (it.read_error || !valid_rec) begin
                        step_record(SCAN_LOOK);
                    end else if (tag == target_tag_q) begin
                        take_chunk(it.record_word, size);
                    end else if (cont) begin
                        step_record(SCAN_SKIP);
                    end else begin
                        step_record(SCAN_LOOK);
                    end
                end
                SCAN_SKIP: begin
                    if (!it.read_error && cont) begin
                        step_record(SCAN_SKIP);
                    end else begin
                        step_record(SCAN_LOOK);
                    end
                end
                SCAN_GATHER: begin
                    if (it.read_error || !valid_rec) begin
                        expect_chunk('0, 3'd0, ST_CHAIN, 1'b1);
                    end else begin
                        take_chunk(it.record_word, size);
                    end
                end
                default: begin
                end
            endcase
        end
    endfunction

    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn) begin
            in_taken <= s_valid && s_ready;
            if (s_valid && s_ready) begin
                track_transfer(s_item);
            end
            if (m_valid && m_ready) begin
                if (expected_chunks.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("unexpected result: data %h bytes %0d total %0d",
                                 m_item.chunk_data, m_item.chunk_bytes, m_item.total_bytes,
                                 " status %0d last %0d", m_item.status, m_item.last);
                    end
                end else begin
                    want = expected_chunks.pop_front();
                    if (m_item.chunk_data !== want.chunk_data
                            || m_item.chunk_bytes !== want.chunk_bytes
                            || m_item.total_bytes !== want.total_bytes
                            || m_item.status !== want.status
                            || m_item.last !== want.last) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("result mismatch: expected data %h bytes %0d total %0d",
                                     want.chunk_data, want.chunk_bytes, want.total_bytes,
                                     " status %0d last %0d", want.status, want.last);
                            $display("                 actual data %h bytes %0d total %0d",
                                     m_item.chunk_data, m_item.chunk_bytes,
                                     m_item.total_bytes, " status %0d last %0d",
                                     m_item.status, m_item.last);
                        end
                    end
                end
            end
        end
    end

    always @(negedge aclk) begin
        logic     nxt_valid;
        in_item_t nxt_item;
        nxt_valid = s_valid && !in_taken;
        nxt_item  = s_item;
        if (aresetn && !nxt_valid && pending_transfers.size() != 0
                && $urandom_range(99) >= send_idle_pct) begin
            nxt_valid = 1'b1;
            nxt_item  = pending_transfers.pop_front();
        end
        s_valid <= nxt_valid;
        s_item  <= nxt_item;
        m_ready <= $urandom_range(99) >= recv_stall_pct;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("otp_tag_record_scanner regression: fail");
            $finish;
        end
    end

    function automatic logic [7:0] other_tag(logic [7:0] t);
        logic [7:0] x;
        do begin
            x = 8'($urandom_range(255));
        end while (x == t);
        return x;
    endfunction

    function automatic logic [63:0] build_record(logic [7:0] tag, logic [2:0] size, logic cont);
        logic [63:0] w;
        logic [7:0]  b7;
        logic [7:0]  b6;
        w  = {$urandom, $urandom};
        b7 = {size, cont, w[59:56]};
        b6 = tag;
        if (!tag[2]) begin
            b7[2] = 1'b0;
        end else if (b7[2]) begin
            b6[2] = w[50];
        end
        w[63:48] = {b7, b6};
        return w;
    endfunction

    task automatic push_record(logic [63:0] word, logic err);
        in_item_t it;
        it.command     = CMD_RECORD;
        it.wanted_tag  = 8'($urandom);
        it.capacity    = 16'($urandom);
        it.record_word = word;
        it.read_error  = err;
        pending_transfers.push_back(it);
        items_queued++;
    endtask

    task automatic push_start(logic [7:0] tag, logic [15:0] cap);
        in_item_t it;
        it.command     = CMD_START;
        it.wanted_tag  = tag;
        it.capacity    = cap;
        it.record_word = {$urandom, $urandom};
        it.read_error  = 1'($urandom_range(1));
        pending_transfers.push_back(it);
        items_queued++;
    endtask

    task automatic push_filler(logic [7:0] t, logic cont);
        case ($urandom_range(3))
            0: push_record(build_record(8'($urandom), $urandom_range(1) ? 3'd7 : 3'd0,
                                       1'($urandom_range(1))), 1'b0);
            1: push_record(build_record(8'($urandom), 3'($urandom_range(7)),
                                       1'($urandom_range(1))), 1'b1);
            default: push_record(build_record(other_tag(t), 3'($urandom_range(1, 6)), cont),
                                 1'b0);
        endcase
    endtask

    task automatic push_search();
        logic [7:0]  t;
        logic [15:0] cap;
        int          lead;
        int          chain;
        logic        err;
        t = ($urandom_range(29) == 0) ? reserved_copy : other_tag(reserved_copy);
        case ($urandom_range(9))
            0: cap = 16'd0;
            1: cap = 16'($urandom);
            2, 3: cap = 16'($urandom_range(1, 6));
            default: cap = 16'($urandom_range(1, 40));
        endcase
        push_start(t, cap);
        lead = $urandom_range(4);
        repeat (lead) begin
            if ($urandom_range(3) == 0) begin
                push_record(build_record(other_tag(t), 3'($urandom_range(1, 6)), 1'b1), 1'b0);
                chain = $urandom_range(3);
                repeat (chain) begin
                    push_record(build_record(8'($urandom), 3'($urandom_range(7)), 1'b1),
                                $urandom_range(7) == 0);
                end
                push_record(build_record(8'($urandom), 3'($urandom_range(7)), 1'b0),
                            $urandom_range(3) == 0);
            end else begin
                push_filler(t, 1'b0);
            end
        end
        if ($urandom_range(9) < 8) begin
            chain = $urandom_range(4);
            push_record(build_record(t, 3'($urandom_range(1, 6)), chain != 0), 1'b0);
            for (int k = 1; k <= chain; k++) begin
                if ($urandom_range(11) == 0) begin
                    err = 1'($urandom_range(1));
                    push_record(build_record(8'($urandom),
                                             err ? 3'($urandom_range(7))
                                                 : ($urandom_range(1) ? 3'd7 : 3'd0),
                                             k < chain), err);
                end else begin
                    push_record(build_record(8'($urandom), 3'($urandom_range(1, 6)),
                                             k < chain), 1'b0);
                end
            end
        end
    endtask

    // Walks the whole tag area; only variant 0 matches, on the last record. The ending depends on the variant.
    task automatic push_full_scan(int variant);
        logic [7:0] t;
        int         slots;
        t     = other_tag(reserved_copy);
        slots = int'((AREA_END - AREA_START) / REC_BYTES);
        push_start(t, (variant == 0) ? 16'hFFFF : 16'($urandom));
        for (int k = 0; k < slots - 1; k++) begin
            if (variant == 1 && k >= slots - 12) begin
                push_record(build_record(other_tag(t), 3'($urandom_range(1, 6)), 1'b1), 1'b0);
            end else if (k == slots - 2) begin
                push_record(build_record(other_tag(t), 3'($urandom_range(1, 6)), 1'b0), 1'b0);
            end else begin
                push_filler(t, $urandom_range(3) == 0);
            end
        end
        if (variant == 0) begin
            push_record(build_record(t, 3'($urandom_range(1, 6)), 1'b1), 1'b0);
        end else begin
            push_filler(t, 1'($urandom_range(1)));
        end
    endtask

    task automatic wait_idle();
        @(posedge aclk);
        while (pending_transfers.size() != 0 || s_valid || expected_chunks.size() != 0) begin
            @(posedge aclk);
        end
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reserved(logic [7:0] v);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge aclk);
        cfg_we <= 1'b0;
        reserved_copy = v;
    endtask

    task automatic run_phase(int send_pct, int stall_pct, logic [7:0] reserved, int variant);
        int stop_at;
        wait_idle();
        send_idle_pct  = send_pct;
        recv_stall_pct = stall_pct;
        write_reserved(reserved);
        stop_at = items_queued + 60;
        while (items_queued < stop_at) begin
            push_search();
        end
        if (variant >= 0) begin
            push_full_scan(variant);
        end
        // A start on the reserved tag leaves the block idle for the next register write.
        push_start(reserved_copy, 16'($urandom));
    endtask

    task automatic load_directed();
        logic [63:0] w;
        push_record(build_record(8'h21, 3'd3, 1'b0), 1'b0);
        push_start(8'h00, 16'h1234);
        push_start(8'hFF, 16'hFFFF);
        w = build_record(8'hFF, 3'd6, 1'b0);
        w[47:0] = '1;
        push_record(w, 1'b0);
        push_start(8'h04, 16'h0000);
        push_record(build_record(8'h04, 3'd6, 1'b0), 1'b1);
        push_record(build_record(8'h04, 3'd7, 1'b0), 1'b0);
        push_record(build_record(8'h04, 3'd0, 1'b0), 1'b0);
        push_record({8'b0110_0100, 8'h00, 48'h0}, 1'b0);
        push_start(8'h12, 16'd10);
        push_record(build_record(8'h13, 3'd2, 1'b1), 1'b0);
        push_record(build_record(8'h12, 3'd4, 1'b0), 1'b0);
        push_record(build_record(8'h14, 3'd2, 1'b1), 1'b0);
        push_record(build_record(8'h12, 3'd4, 1'b1), 1'b1);
        push_record(build_record(8'h12, 3'd6, 1'b1), 1'b0);
        push_record(build_record(8'h77, 3'd6, 1'b1), 1'b0);
        push_start(8'h33, 16'd100);
        push_record(build_record(8'h33, 3'd2, 1'b1), 1'b0);
        push_record(build_record(8'h33, 3'd0, 1'b1), 1'b0);
        push_start(8'h44, 16'd100);
        push_record(build_record(8'h44, 3'd5, 1'b0), 1'b1);
        push_start(8'h55, 16'd1);
        push_record(build_record(8'h55, 3'd6, 1'b1), 1'b0);
        push_start(8'h66, 16'hFFFF);
        push_record(build_record(8'h66, 3'd5, 1'b1), 1'b0);
        push_record({8'b1100_0000, 56'h0}, 1'b0);
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        load_directed();
        run_phase(0, 0, 8'hFF, 0);
        run_phase(68, 0, 8'($urandom), -1);
        run_phase(0, 68, 8'h00, 1);
        run_phase(14, 14, 8'($urandom), 2);
        run_phase(0, 0, 8'h04, -1);
        wait_idle();
        if (mismatches == 0 && expected_chunks.size() == 0) begin
            $display("otp_tag_record_scanner regression: pass");
        end else begin
            $display("otp_tag_record_scanner regression: fail");
        end
        $finish;
    end
endmodule
